### rtl/core/virtual_uart_register_block_assert.svh
// Assertion macros used by the UART register block checker.
`ifndef VIRTUAL_UART_REGISTER_BLOCK_ASSERT_SVH
`define VIRTUAL_UART_REGISTER_BLOCK_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define VURB_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vurb assertion failed");

// Check that cons holds in the cycle after ante.
`define VURB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vurb assertion failed");

`endif

### rtl/core/vurb_pkg.sv
// Shared types and constants of the UART register block.
package vurb_pkg;

    localparam int RX_DEPTH = 4096;
    localparam int RX_AW    = $clog2(RX_DEPTH);
    localparam int FILL_W   = RX_AW + 1;

    localparam logic [3:0] RXCNT_MAX = 4'd15;

    localparam logic [11:0] OFF_CONTROL = 12'h004;
    localparam logic [11:0] OFF_STATUS  = 12'h010;
    localparam logic [11:0] OFF_FSTATUS = 12'h018;
    localparam logic [11:0] OFF_TX      = 12'h020;
    localparam logic [11:0] OFF_RX      = 12'h024;

    localparam logic [1:0] CT_MODE_IRQ = 2'd1;
    localparam int CT_RXTO_ENA_BIT = 9;
    localparam int CT_TXTH_ENA_BIT = 13;
    localparam int ST_TXTH_BIT     = 5;
    localparam int ST_RXTO_BIT     = 9;

    typedef enum logic [1:0] {
        MODE_READ   = 2'd0,
        MODE_WRITE  = 2'd1,
        MODE_INJECT = 2'd2,
        MODE_POLL   = 2'd3
    } mode_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;     // capture the item
        logic exec;     // run the item
        logic finish;   // deliver popped receive byte
    } cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic pop_hit;  // item pops a byte from the ring
    } stat_t;

endpackage

### rtl/core/virtual_uart_register_block.sv
// Top level of the UART register window with host-filled receive ring.
// done rises once the item has passed through EXEC, and also through POP
//   for a receive pop; the result transfers at the edge that ends the done cycle.
// No new item is taken while busy; an item that pops the ring also passes
//   through POP, for the registered read port of the ring memory.
// Results last one cycle on done and cannot be held off by the receiver.
// Reset (rst_n low, asynchronous) empties the ring and clears control, flags,
//   interrupt and irq_enable; ring contents are left as they are.
module virtual_uart_register_block
    import vurb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // command channel: an item transfers when start is high and busy is low
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [11:0] reg_offset,
    input  logic [31:0] write_data,
    input  logic [7:0]  rx_byte,
    // result channel: one transfer per item, marked by done
    output logic        done,
    output logic [31:0] read_data,
    output logic        tx_valid,
    output logic [7:0]  tx_byte,
    output logic        inject_accepted,
    output logic        irq_out,
    // interrupt enable register, written when irq_enable_we is high
    input  logic        irq_enable_we,
    input  logic        irq_enable
);

    cmd_t  cmd;
    stat_t stat;

    // Controller: IDLE takes the item, EXEC runs it, POP waits on ring data.
    vurb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Datapath: register window, sticky flags, ring memory and result registers.
    // Results stay on the output registers until the next item completes, so
    // a new item can transfer in the same cycle that done is shown.
    vurb_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .irq_enable_we   (irq_enable_we),
        .irq_enable      (irq_enable),
        .mode            (mode),
        .reg_offset      (reg_offset),
        .write_data      (write_data),
        .rx_byte         (rx_byte),
        .done            (done),
        .read_data       (read_data),
        .tx_valid        (tx_valid),
        .tx_byte         (tx_byte),
        .inject_accepted (inject_accepted),
        .irq_out         (irq_out)
    );

endmodule

### rtl/core/vurb_ctrl.sv
// Sequencing state machine of the UART register block.
module vurb_ctrl
    import vurb_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  stat_t stat,
    output cmd_t  cmd,
    output logic  busy
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_POP  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = stat.pop_hit ? S_POP : S_IDLE;
            end
            S_POP:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

### rtl/core/vurb_datapath.sv
// Register window, receive ring and result registers of the UART block.
module vurb_datapath
    import vurb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output stat_t       stat,
    input  logic        irq_enable_we,
    input  logic        irq_enable,
    input  logic [1:0]  mode,
    input  logic [11:0] reg_offset,
    input  logic [31:0] write_data,
    input  logic [7:0]  rx_byte,
    output logic        done,
    output logic [31:0] read_data,
    output logic        tx_valid,
    output logic [7:0]  tx_byte,
    output logic        inject_accepted,
    output logic        irq_out
);

    // captured item
    mode_t       mode_reg;
    logic [11:0] offset_reg;
    logic [31:0] wdata_reg;
    logic [7:0]  byte_reg;

    // architectural state
    logic [RX_AW-1:0]  head_reg, head_next;
    logic [RX_AW-1:0]  tail_reg, tail_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [31:0]       ctrl_reg, ctrl_next;
    logic              rxto_reg, rxto_next;
    logic              txth_reg, txth_next;
    logic              irq_reg, irq_next;
    logic              irq_en_reg;

    // results
    logic              done_reg, done_next;
    logic [31:0]       rdata_reg, rdata_next;
    logic              txv_reg, txv_next;
    logic [7:0]        txb_reg, txb_next;
    logic              acc_reg, acc_next;

    logic [7:0] ring [RX_DEPTH];
    logic [7:0] mem_rd_reg;

    logic       not_empty;
    logic       inj_ok;
    logic       rxto_set;
    logic       txth_set;
    logic [3:0] rx_count;
    logic       rx_full;
    logic [31:0] status_val;
    logic [31:0] fstatus_val;

    assign not_empty = (fill_reg != '0);
    assign inj_ok    = (mode_reg == MODE_INJECT) && (fill_reg < FILL_W'(RX_DEPTH));
    assign stat.pop_hit = (mode_reg == MODE_READ) && (offset_reg == OFF_RX) && not_empty;

    // status as the recompute leaves it
    assign rxto_set = rxto_reg | (not_empty && (ctrl_reg[1:0] == CT_MODE_IRQ)
                                 && ctrl_reg[CT_RXTO_ENA_BIT]);
    assign txth_set = txth_reg | ((ctrl_reg[3:2] == CT_MODE_IRQ) && ctrl_reg[CT_TXTH_ENA_BIT]);
    assign rx_full  = (fill_reg > FILL_W'(RXCNT_MAX));
    assign rx_count = rx_full ? RXCNT_MAX : fill_reg[3:0];

    assign status_val  = {22'd0, rxto_set, 3'd0, txth_set, 1'b0, 1'b0, 1'b1, 1'b1, not_empty};
    assign fstatus_val = {23'd0, rx_full, 4'd0, rx_count};

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        fill_next  = fill_reg;
        ctrl_next  = ctrl_reg;
        rxto_next  = rxto_reg;
        txth_next  = txth_reg;
        irq_next   = irq_reg;
        done_next  = cmd.finish;
        rdata_next = rdata_reg;
        txv_next   = txv_reg;
        txb_next   = txb_reg;
        acc_next   = acc_reg;

        if (cmd.finish)
        begin
            rdata_next = {24'd0, mem_rd_reg};
        end

        if (cmd.exec)
        begin
            done_next  = !stat.pop_hit;
            rdata_next = '0;
            txv_next   = 1'b0;
            txb_next   = '0;
            acc_next   = 1'b0;

            if (mode_reg != MODE_INJECT)
            begin
                rxto_next = rxto_set;
                txth_next = txth_set;
                irq_next  = irq_en_reg & (rxto_set | txth_set);
            end

            unique case (mode_reg)
                MODE_INJECT:
                begin
                    if (inj_ok)
                    begin
                        tail_next = tail_reg + 1'b1;
                        fill_next = fill_reg + 1'b1;
                        acc_next  = 1'b1;
                    end
                end
                MODE_WRITE:
                begin
                    priority if (offset_reg == OFF_CONTROL)
                    begin
                        ctrl_next = wdata_reg;
                    end
                    else if (offset_reg == OFF_TX)
                    begin
                        txv_next = 1'b1;
                        txb_next = wdata_reg[7:0];
                    end
                    else if (offset_reg == OFF_STATUS)
                    begin
                        // write one to clear
                        rxto_next = rxto_set & ~wdata_reg[ST_RXTO_BIT];
                        txth_next = txth_set & ~wdata_reg[ST_TXTH_BIT];
                    end
                    else
                    begin
                        // unmapped or read-only offset: drop the write
                    end
                end
                MODE_READ:
                begin
                    priority if (offset_reg == OFF_CONTROL)
                    begin
                        rdata_next = ctrl_reg;
                    end
                    else if (offset_reg == OFF_RX)
                    begin
                        if (not_empty)
                        begin
                            head_next = head_reg + 1'b1;
                            fill_next = fill_reg - 1'b1;
                        end
                    end
                    else if (offset_reg == OFF_STATUS)
                    begin
                        rdata_next = status_val;
                    end
                    else if (offset_reg == OFF_FSTATUS)
                    begin
                        rdata_next = fstatus_val;
                    end
                    else
                    begin
                        // unmapped or write-only offset: read data stays zero
                    end
                end
                MODE_POLL:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    // hold the captured item
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg   <= mode_t'(mode);
            offset_reg <= reg_offset;
            wdata_reg  <= write_data;
            byte_reg   <= rx_byte;
        end
    end

    // receive ring
    always_ff @(posedge clk)
    begin
        if (cmd.exec && inj_ok)
        begin
            ring[tail_reg] <= byte_reg;
        end
        if (cmd.exec && stat.pop_hit)
        begin
            mem_rd_reg <= ring[head_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= '0;
            fill_reg   <= '0;
            ctrl_reg   <= '0;
            rxto_reg   <= 1'b0;
            txth_reg   <= 1'b0;
            irq_reg    <= 1'b0;
            irq_en_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            fill_reg <= fill_next;
            ctrl_reg <= ctrl_next;
            rxto_reg <= rxto_next;
            txth_reg <= txth_next;
            irq_reg  <= irq_next;
            done_reg <= done_next;
            if (irq_enable_we)
            begin
                irq_en_reg <= irq_enable;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= rdata_next;
        txv_reg   <= txv_next;
        txb_reg   <= txb_next;
        acc_reg   <= acc_next;
    end

    assign done            = done_reg;
    assign read_data       = rdata_reg;
    assign tx_valid        = txv_reg;
    assign tx_byte         = txb_reg;
    assign inject_accepted = acc_reg;
    assign irq_out         = irq_reg;

endmodule

### rtl/core/vurb_checker.sv
// Port-level checks of the UART register block, bound to the top level.
`include "virtual_uart_register_block_assert.svh"

module vurb_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic        tx_valid,
    input logic [7:0]  tx_byte,
    input logic        inject_accepted
);

    `VURB_ASSERT_NEXT(a_take_sets_busy, start && !busy, busy)
    `VURB_ASSERT_NEXT(a_done_single, done, !done)
    `VURB_ASSERT_SAME(a_tx_inject_excl, done, !(tx_valid && inject_accepted))
    `VURB_ASSERT_SAME(a_tx_byte_zero, done && !tx_valid, tx_byte == 8'd0)

endmodule

bind virtual_uart_register_block vurb_checker u_vurb_checker (.*);
